### rtl/sdi_pkg.sv
// Shared types and constants for the SD-card SPI start-up sequencer.
// No dependencies.
package sdi_pkg;

	typedef enum logic [4:0] {
		PH_IDLE, PH_DUMMY, PH_SEL0, PH_READY0, PH_DESEL, PH_SEL, PH_READY, PH_SEND,
		PH_POLL, PH_R7, PH_OCR, PH_TOKEN, PH_CSD, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		CMD_GO_IDLE, CMD_IF_COND, CMD_APP, CMD_OP_COND, CMD_READ_OCR, CMD_BLOCKLEN,
		CMD_SEND_CSD
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_BUSY, OUT_OK, OUT_TIMEOUT, OUT_IF_ERR, OUT_BAD_CARD
	} outcome_t;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;

	localparam logic [1:0] REG_READY_TIMEOUT  = 2'd0;
	localparam logic [1:0] REG_OPCOND_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_FILLER_CRC     = 2'd2;

	localparam logic [7:0] BYTE_IDLE    = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN   = 8'hFE;
	localparam logic [7:0] CMD_START    = 8'h40;
	localparam logic [7:0] CHECK_PAT    = 8'hAA;
	localparam logic [7:0] CRC_CMD0     = 8'h95;
	localparam logic [7:0] CRC_CMD8     = 8'h87;
	localparam logic [7:0] R1_IDLE      = 8'h01;
	localparam logic [7:0] VHS_27_36    = 8'h01;
	localparam logic [7:0] BLEN_512_HI  = 8'h02;
	localparam logic [7:0] HCS_BIT      = 8'h40;

	function automatic logic [7:0] cmd_code(input cmd_t c);
		logic [7:0] r;
		begin
			unique case (c)
				CMD_GO_IDLE:  r = 8'd0;
				CMD_IF_COND:  r = 8'd8;
				CMD_APP:      r = 8'd55;
				CMD_OP_COND:  r = 8'd41;
				CMD_READ_OCR: r = 8'd58;
				CMD_BLOCKLEN: r = 8'd16;
				CMD_SEND_CSD: r = 8'd9;
				default:      r = 8'd0;
			endcase
			return r;
		end
	endfunction

endpackage

### rtl/sdi_in_if.sv
// Input channel: event kind and received byte.
// No dependencies.
interface sdi_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;

	modport source(output valid, kind, rx_byte, input ready);
	modport sink(input valid, kind, rx_byte, output ready);
endinterface

### rtl/sdi_out_if.sv
// Result channel: next SPI byte request, chip select and status.
// No dependencies.
interface sdi_out_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        card_selected;
	logic        finished;
	logic [2:0]  outcome;
	logic        version_two;
	logic        high_capacity;
	logic [31:0] capacity_blocks;
	logic        fast_clock;

	modport source(output valid, tx_valid, tx_byte, card_selected, finished, outcome,
		version_two, high_capacity, capacity_blocks, fast_clock, input ready);
	modport sink(input valid, tx_valid, tx_byte, card_selected, finished, outcome,
		version_two, high_capacity, capacity_blocks, fast_clock, output ready);
endinterface

### rtl/sdi_csd_decode.sv
// CSD capacity decode (v1 and v2 layouts) into 512-byte blocks, saturating.
// Combinational; no dependencies.
module sdi_csd_decode (
	input  logic [5:0][7:0] csd_bytes,   // CSD bytes 5..10, index 0 = byte 5
	input  logic            high_cap,
	output logic [31:0]     blocks
);
	logic [21:0] hc_size;
	logic [22:0] hc_sum;
	logic [11:0] sc_size;
	logic [12:0] sc_sum;
	logic [2:0]  sc_mult;
	logic [3:0]  sc_bl;
	logic [4:0]  sc_shift;
	logic [36:0] sc_wide;

	always_comb begin
		hc_size  = {csd_bytes[2][5:0], csd_bytes[3], csd_bytes[4]};
		hc_sum   = {1'b0, hc_size} + 23'd1;
		sc_size  = {csd_bytes[1][1:0], csd_bytes[2], csd_bytes[3][7:6]};
		sc_sum   = {1'b0, sc_size} + 13'd1;
		sc_mult  = {csd_bytes[4][1:0], csd_bytes[5][7]};
		sc_bl    = csd_bytes[0][3:0];
		sc_shift = {2'b00, sc_mult} + {1'b0, sc_bl} + 5'd2;
		sc_wide  = {24'd0, sc_sum} << sc_shift;
		if (high_cap) begin
			blocks = hc_sum[22] ? 32'hFFFF_FFFF : {hc_sum[21:0], 10'd0};
		end else begin
			blocks = {4'd0, sc_wide[36:9]};
		end
	end
endmodule

### rtl/sd_spi_init_sequencer_top.sv
// SD-card SPI-mode start-up sequencer, top level.
// Depends on sdi_pkg, sdi_in_if, sdi_out_if, sdi_csd_decode.
//
//  channel | dir | contents
//  in_ch   | in  | kind (start / byte exchanged / tick), rx_byte
//  out_ch  | out | tx request and byte, chip select, status, card info
//  cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One transaction per cycle unless stalled; the result is registered on accept.
// The state update and result are formed in one pass from the state registers.
// A new transaction is taken while the output register is empty or being drained.
// arst_n clears control state and loads register defaults.
module sd_spi_init_sequencer_top import sdi_pkg::*; #(
	parameter int DUMMY_BYTES   = 10,
	parameter int R1_POLL_TRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	sdi_in_if.sink      in_ch,
	sdi_out_if.source   out_ch
);
	localparam int BCW = ($clog2(DUMMY_BYTES + 1) > 5) ? $clog2(DUMMY_BYTES + 1) : 5;
	localparam int PTW = $clog2(R1_POLL_TRIES + 1);

	logic [15:0] ready_to_q, opcond_to_q;
	logic [7:0]  filler_crc_q;

	phase_t      phase_q, n_phase;
	cmd_t        cmd_q, n_cmd;
	outcome_t    result_q, n_result;
	logic [BCW-1:0] bc_q, n_bc, bc_inc;
	logic [15:0] wait_q, n_wait, loop_q, n_loop;
	logic [PTW-1:0] poll_q, n_poll, poll_inc;
	logic        v2_q, n_v2, hc_q, n_hc;
	logic [31:0] blocks_q, n_blocks, csd_blocks;
	logic [7:0]  reply_q [16];
	logic [5:0][7:0] csd_bytes;

	logic        accept, busy, req, r1_go, rw_en, sel;
	logic [7:0]  r1_val, tx, frame;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = !out_ch.valid || out_ch.ready;
	assign busy         = (phase_q != PH_IDLE) && (phase_q != PH_DONE);
	assign bc_inc       = bc_q + 1'b1;
	assign poll_inc     = poll_q + 1'b1;

	always_comb begin
		for (int i = 0; i < 6; i++) csd_bytes[i] = reply_q[i + 5];
	end

	sdi_csd_decode u_csd (
		.csd_bytes (csd_bytes),
		.high_cap  (hc_q),
		.blocks    (csd_blocks)
	);

	always_comb begin
		n_phase = phase_q; n_cmd = cmd_q; n_result = result_q; n_bc = bc_q;
		n_wait = wait_q; n_loop = loop_q; n_poll = poll_q; n_v2 = v2_q; n_hc = hc_q;
		n_blocks = blocks_q;
		req = 1'b0; r1_go = 1'b0; r1_val = BYTE_IDLE; rw_en = 1'b0;
		if (accept) begin
			if (in_ch.kind == KIND_START) begin
				n_phase = PH_DUMMY; n_cmd = CMD_GO_IDLE; n_result = OUT_BUSY; n_bc = '0;
				n_wait = '0; n_loop = '0; n_poll = '0; n_v2 = 1'b0; n_hc = 1'b0;
				n_blocks = '0; req = 1'b1;
			end else if (in_ch.kind == KIND_BYTE) begin
				if (busy) begin
					unique case (phase_q)
						PH_DUMMY: begin
							n_bc = bc_inc;
							if (bc_inc >= BCW'(DUMMY_BYTES)) begin
								n_phase = PH_SEL0; n_bc = '0;
							end
						end
						PH_SEL0: begin
							n_wait = '0; n_phase = PH_READY0;
						end
						PH_READY0: begin
							if (in_ch.rx_byte == BYTE_IDLE) begin
								n_cmd = CMD_GO_IDLE; n_phase = PH_DESEL;
							end else if (wait_q >= ready_to_q) begin
								n_result = OUT_IF_ERR; n_phase = PH_DONE;
							end
						end
						PH_DESEL: n_phase = PH_SEL;
						PH_SEL: begin
							n_wait = '0; n_phase = PH_READY;
						end
						PH_READY: begin
							if (in_ch.rx_byte == BYTE_IDLE) begin
								n_phase = PH_SEND; n_bc = '0;
							end else if (wait_q >= ready_to_q) begin
								r1_go = 1'b1;
							end
						end
						PH_SEND: begin
							n_bc = bc_inc;
							if (bc_inc >= BCW'(6)) begin
								n_phase = PH_POLL; n_poll = '0;
							end
						end
						PH_POLL: begin
							n_poll = poll_inc;
							if (!in_ch.rx_byte[7] || poll_inc >= PTW'(R1_POLL_TRIES)) begin
								r1_go = 1'b1; r1_val = in_ch.rx_byte;
							end
						end
						PH_R7: begin
							rw_en = 1'b1; n_bc = bc_inc;
							if (bc_inc >= BCW'(4)) begin
								if (reply_q[2] == VHS_27_36 && in_ch.rx_byte == CHECK_PAT) begin
									n_v2 = 1'b1; n_loop = '0; n_cmd = CMD_APP; n_phase = PH_DESEL;
								end else begin
									n_result = OUT_BAD_CARD; n_phase = PH_DONE;
								end
							end
						end
						PH_OCR: begin
							rw_en = 1'b1; n_bc = bc_inc;
							if (bc_inc >= BCW'(4)) begin
								n_hc = reply_q[0][6];
								n_cmd = reply_q[0][6] ? CMD_SEND_CSD : CMD_BLOCKLEN;
								n_phase = PH_DESEL;
							end
						end
						PH_TOKEN: begin
							if (in_ch.rx_byte == BYTE_TOKEN) begin
								n_phase = PH_CSD; n_bc = '0;
							end else if (in_ch.rx_byte != BYTE_IDLE || wait_q >= ready_to_q) begin
								n_result = OUT_OK; n_phase = PH_DONE;
							end
						end
						PH_CSD: begin
							rw_en = (bc_q < BCW'(16)); n_bc = bc_inc;
							if (bc_inc >= BCW'(18)) begin
								n_blocks = csd_blocks; n_result = OUT_OK; n_phase = PH_DONE;
							end
						end
						default: ;
					endcase
					if (r1_go) begin
						unique case (cmd_q)
							CMD_GO_IDLE: begin
								if (r1_val == R1_IDLE) begin
									n_cmd = CMD_IF_COND; n_phase = PH_DESEL;
								end else begin
									n_result = (r1_val == BYTE_IDLE) ? OUT_TIMEOUT : OUT_IF_ERR;
									n_phase = PH_DONE;
								end
							end
							CMD_IF_COND: begin
								if (r1_val == R1_IDLE) begin
									n_phase = PH_R7; n_bc = '0;
								end else begin
									n_loop = '0; n_cmd = CMD_APP; n_phase = PH_DESEL;
								end
							end
							CMD_APP: begin
								n_cmd = CMD_OP_COND; n_phase = PH_DESEL;
							end
							CMD_OP_COND: begin
								if (r1_val == 8'd0) begin
									n_cmd = v2_q ? CMD_READ_OCR : CMD_BLOCKLEN; n_phase = PH_DESEL;
								end else if (loop_q >= opcond_to_q) begin
									n_result = OUT_TIMEOUT; n_phase = PH_DONE;
								end else begin
									n_cmd = CMD_APP; n_phase = PH_DESEL;
								end
							end
							CMD_READ_OCR: begin
								if (r1_val == 8'd0) begin
									n_phase = PH_OCR; n_bc = '0;
								end else begin
									n_cmd = CMD_BLOCKLEN; n_phase = PH_DESEL;
								end
							end
							CMD_BLOCKLEN: begin
								if (r1_val != 8'd0) begin
									n_result = OUT_IF_ERR; n_phase = PH_DONE;
								end else begin
									n_cmd = CMD_SEND_CSD; n_phase = PH_DESEL;
								end
							end
							default: begin
								if (r1_val == 8'd0) begin
									n_phase = PH_TOKEN; n_wait = '0;
								end else begin
									n_result = OUT_OK; n_phase = PH_DONE;
								end
							end
						endcase
					end
					req = (n_phase != PH_DONE);
				end
			end else if (busy) begin
				if (wait_q != 16'hFFFF) n_wait = wait_q + 16'd1;
				if (loop_q != 16'hFFFF) n_loop = loop_q + 16'd1;
			end
		end
	end

	always_comb begin
		frame = 8'd0;
		if (n_bc == BCW'(0)) begin
			frame = CMD_START | cmd_code(n_cmd);
		end else if (n_bc == BCW'(5)) begin
			frame = (n_cmd == CMD_GO_IDLE) ? CRC_CMD0 :
				(n_cmd == CMD_IF_COND) ? CRC_CMD8 : filler_crc_q;
		end else if (n_cmd == CMD_IF_COND && n_bc == BCW'(3)) begin
			frame = VHS_27_36;
		end else if (n_cmd == CMD_IF_COND && n_bc == BCW'(4)) begin
			frame = CHECK_PAT;
		end else if (n_cmd == CMD_BLOCKLEN && n_bc == BCW'(3)) begin
			frame = BLEN_512_HI;
		end else if (n_cmd == CMD_OP_COND && n_bc == BCW'(1)) begin
			frame = n_v2 ? HCS_BIT : 8'd0;
		end
		tx  = req ? ((n_phase == PH_SEND) ? frame : BYTE_IDLE) : 8'd0;
		sel = !(n_phase == PH_IDLE || n_phase == PH_DONE || n_phase == PH_DUMMY ||
			n_phase == PH_DESEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_to_q   <= 16'd500;
			opcond_to_q  <= 16'd1000;
			filler_crc_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_READY_TIMEOUT:  ready_to_q   <= cfg_wdata;
				REG_OPCOND_TIMEOUT: opcond_to_q  <= cfg_wdata;
				REG_FILLER_CRC:     filler_crc_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cmd_q <= CMD_GO_IDLE; result_q <= OUT_BUSY;
			bc_q <= '0; wait_q <= '0; loop_q <= '0; poll_q <= '0;
			v2_q <= 1'b0; hc_q <= 1'b0; blocks_q <= '0;
		end else begin
			phase_q <= n_phase; cmd_q <= n_cmd; result_q <= n_result;
			bc_q <= n_bc; wait_q <= n_wait; loop_q <= n_loop; poll_q <= n_poll;
			v2_q <= n_v2; hc_q <= n_hc; blocks_q <= n_blocks;
		end
	end

	always_ff @(posedge clk) begin
		if (rw_en) reply_q[bc_q[3:0]] <= in_ch.rx_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (accept) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_ch.tx_valid        <= req;
			out_ch.tx_byte         <= tx;
			out_ch.card_selected   <= sel;
			out_ch.finished        <= (n_phase == PH_DONE);
			out_ch.outcome         <= n_result;
			out_ch.version_two     <= n_v2;
			out_ch.high_capacity   <= n_hc;
			out_ch.capacity_blocks <= n_blocks;
			out_ch.fast_clock      <= (n_phase == PH_DONE) && (n_result == OUT_OK);
		end
	end
endmodule

### rtl/sdi_checker.sv
// Port-level checks for the start-up sequencer, bound to the top level.
// Depends on sdi_pkg.
module sdi_checker import sdi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tx_valid,
	input logic        card_selected,
	input logic        finished,
	input logic [2:0]  outcome,
	input logic        fast_clock,
	input logic [7:0]  tx_byte
);
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid) else $error("transaction without result");

	a_done_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> !tx_valid && !card_selected && outcome != OUT_BUSY)
		else $error("finished with bus activity or busy status");

	a_fast_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_clock |-> finished && outcome == OUT_OK)
		else $error("fast clock before successful end");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(outcome))
		else $error("stalled result changed");
endmodule

bind sd_spi_init_sequencer_top sdi_checker u_sdi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.tx_valid      (out_ch.tx_valid),
	.card_selected (out_ch.card_selected),
	.finished      (out_ch.finished),
	.outcome       (out_ch.outcome),
	.fast_clock    (out_ch.fast_clock),
	.tx_byte       (out_ch.tx_byte)
);

### bench/tb.sv
// Testbench for sd_spi_init_sequencer_top: card responses are modelled in the bench,
// each result is checked against a local predictor of the start-up sequence.
// Depends on sdi_pkg, sdi_in_if, sdi_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
	import sdi_pkg::*;

	localparam int N_DUMMY = 10;
	localparam int N_POLL  = 8;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        card_selected;
		logic        finished;
		logic [2:0]  outcome;
		logic        version_two;
		logic        high_capacity;
		logic [31:0] capacity_blocks;
		logic        fast_clock;
	} seq_result_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] rx;
		logic       typed;
		seq_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	sdi_in_if  in_ch();
	sdi_out_if out_ch();

	sd_spi_init_sequencer_top #(.DUMMY_BYTES(N_DUMMY), .R1_POLL_TRIES(N_POLL)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] p_ready_to, p_opcond_to;
	logic [7:0]  p_crc;
	phase_t      p_phase;
	cmd_t        p_cmd;
	logic [4:0]  p_count;
	logic [15:0] p_wait, p_loop;
	logic [3:0]  p_tries;
	logic [7:0]  p_reply [16];
	logic        p_v2, p_hc;
	logic [2:0]  p_code;
	logic [31:0] p_blocks;

	seq_result_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit long_hold = 1'b0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void seq_clear();
		p_phase = PH_IDLE; p_count = 0; p_wait = 0; p_loop = 0; p_tries = 0;
		for (int i = 0; i < 16; i++) p_reply[i] = '0;
		p_v2 = 0; p_hc = 0; p_code = OUT_BUSY; p_blocks = 0; p_cmd = CMD_GO_IDLE;
	endfunction

	function automatic logic [7:0] cmd_index(input cmd_t c);
		case (c)
			CMD_GO_IDLE:  return 8'd0;
			CMD_IF_COND:  return 8'd8;
			CMD_APP:      return 8'd55;
			CMD_OP_COND:  return 8'd41;
			CMD_READ_OCR: return 8'd58;
			CMD_BLOCKLEN: return 8'd16;
			default:      return 8'd9;
		endcase
	endfunction

	function automatic logic [7:0] frame_byte();
		logic [7:0] b;
		b = 8'h00;
		if (p_count == 0) b = CMD_START | cmd_index(p_cmd);
		else if (p_count == 5) b = (p_cmd == CMD_GO_IDLE) ? CRC_CMD0 :
			(p_cmd == CMD_IF_COND) ? CRC_CMD8 : p_crc;
		else if (p_cmd == CMD_IF_COND && p_count == 3) b = VHS_27_36;
		else if (p_cmd == CMD_IF_COND && p_count == 4) b = CHECK_PAT;
		else if (p_cmd == CMD_BLOCKLEN && p_count == 3) b = BLEN_512_HI;
		else if (p_cmd == CMD_OP_COND && p_count == 1) b = p_v2 ? HCS_BIT : 8'h00;
		return b;
	endfunction

	function automatic void start_cmd(input cmd_t c);
		p_cmd = c; p_phase = PH_DESEL;
	endfunction

	function automatic void end_seq(input outcome_t o);
		p_code = o; p_phase = PH_DONE;
	endfunction

	function automatic void decode_capacity();
		logic [63:0] total;
		logic [31:0] cs, mult, bl;
		if (p_hc) begin
			cs = {10'd0, p_reply[7][5:0], p_reply[8], p_reply[9]};
			total = (64'(cs) + 1) * 1024;
		end else begin
			cs = {20'd0, p_reply[6][1:0], p_reply[7], p_reply[8][7:6]};
			mult = {29'd0, p_reply[9][1:0], p_reply[10][7]};
			bl = {28'd0, p_reply[5][3:0]};
			total = ((64'(cs) + 1) << (mult + 2 + bl)) >> 9;
		end
		p_blocks = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
	endfunction

	function automatic void take_r1(input logic [7:0] r1);
		case (p_cmd)
			CMD_GO_IDLE:
				if (r1 == R1_IDLE) start_cmd(CMD_IF_COND);
				else end_seq(r1 == BYTE_IDLE ? OUT_TIMEOUT : OUT_IF_ERR);
			CMD_IF_COND:
				if (r1 == R1_IDLE) begin
					p_phase = PH_R7; p_count = 0;
				end else begin
					p_loop = 0; start_cmd(CMD_APP);
				end
			CMD_APP: start_cmd(CMD_OP_COND);
			CMD_OP_COND:
				if (r1 == 0) start_cmd(p_v2 ? CMD_READ_OCR : CMD_BLOCKLEN);
				else if (p_loop >= p_opcond_to) end_seq(OUT_TIMEOUT);
				else start_cmd(CMD_APP);
			CMD_READ_OCR:
				if (r1 == 0) begin
					p_phase = PH_OCR; p_count = 0;
				end else start_cmd(CMD_BLOCKLEN);
			CMD_BLOCKLEN:
				if (r1 != 0) end_seq(OUT_IF_ERR);
				else start_cmd(CMD_SEND_CSD);
			default:
				if (r1 == 0) begin
					p_phase = PH_TOKEN; p_wait = 0;
				end else end_seq(OUT_OK);
		endcase
	endfunction

	function automatic void take_byte(input logic [7:0] rx);
		case (p_phase)
			PH_DUMMY: begin
				p_count++;
				if (p_count >= N_DUMMY) begin
					p_phase = PH_SEL0; p_count = 0;
				end
			end
			PH_SEL0: begin
				p_wait = 0; p_phase = PH_READY0;
			end
			PH_READY0:
				if (rx == BYTE_IDLE) start_cmd(CMD_GO_IDLE);
				else if (p_wait >= p_ready_to) end_seq(OUT_IF_ERR);
			PH_DESEL: p_phase = PH_SEL;
			PH_SEL: begin
				p_wait = 0; p_phase = PH_READY;
			end
			PH_READY:
				if (rx == BYTE_IDLE) begin
					p_phase = PH_SEND; p_count = 0;
				end else if (p_wait >= p_ready_to) take_r1(BYTE_IDLE);
			PH_SEND: begin
				p_count++;
				if (p_count >= 6) begin
					p_phase = PH_POLL; p_tries = 0;
				end
			end
			PH_POLL: begin
				p_tries++;
				if (rx < 8'h80 || p_tries >= N_POLL) take_r1(rx);
			end
			PH_R7: begin
				p_reply[p_count[3:0]] = rx;
				p_count++;
				if (p_count >= 4) begin
					if (p_reply[2] == VHS_27_36 && p_reply[3] == CHECK_PAT) begin
						p_v2 = 1; p_loop = 0; start_cmd(CMD_APP);
					end else end_seq(OUT_BAD_CARD);
				end
			end
			PH_OCR: begin
				p_reply[p_count[3:0]] = rx;
				p_count++;
				if (p_count >= 4) begin
					p_hc = p_reply[0][6];
					start_cmd(p_hc ? CMD_SEND_CSD : CMD_BLOCKLEN);
				end
			end
			PH_TOKEN:
				if (rx == BYTE_TOKEN) begin
					p_phase = PH_CSD; p_count = 0;
				end else if (rx != BYTE_IDLE || p_wait >= p_ready_to) end_seq(OUT_OK);
			PH_CSD: begin
				if (p_count < 16) p_reply[p_count[3:0]] = rx;
				p_count++;
				if (p_count >= 18) begin
					decode_capacity(); end_seq(OUT_OK);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic seq_result_t predict_step(input logic [1:0] kind, input logic [7:0] rx);
		seq_result_t r;
		logic busy, req;
		busy = p_phase != PH_IDLE && p_phase != PH_DONE;
		req = 0;
		if (kind == KIND_START) begin
			seq_clear(); p_phase = PH_DUMMY; req = 1;
		end else if (kind == KIND_BYTE) begin
			if (busy) begin
				take_byte(rx); req = p_phase != PH_DONE;
			end
		end else if (busy) begin
			if (p_wait != 16'hFFFF) p_wait++;
			if (p_loop != 16'hFFFF) p_loop++;
		end
		r.tx_valid = req;
		r.tx_byte = req ? (p_phase == PH_SEND ? frame_byte() : BYTE_IDLE) : 8'h00;
		r.card_selected = !(p_phase inside {PH_IDLE, PH_DONE, PH_DUMMY, PH_DESEL});
		r.finished = p_phase == PH_DONE;
		r.outcome = p_code;
		r.version_two = p_v2;
		r.high_capacity = p_hc;
		r.capacity_blocks = p_blocks;
		r.fast_clock = r.finished && p_code == OUT_OK;
		return r;
	endfunction

	// input driver; valid stays up between back-to-back transactions
	task automatic send_event(input logic [1:0] kind, input logic [7:0] rx,
			input logic typed = 0, input seq_result_t want = '0);
		seq_result_t r;
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.rx_byte <= rx;
		do @(posedge clk); while (!in_ch.ready);
		r = predict_step(kind, rx);
		if (typed && r != want) report("directed row", r[31:0], want[31:0]);
		expected_q.push_back(r);
	endtask

	always @(posedge clk) begin
		seq_result_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.tx_valid, out_ch.tx_byte, out_ch.card_selected, out_ch.finished,
				out_ch.outcome, out_ch.version_two, out_ch.high_capacity,
				out_ch.capacity_blocks, out_ch.fast_clock};
			if (expected_q.size() == 0) report("unexpected transaction", 32'd0, 32'd0);
			else begin
				want = expected_q.pop_front();
				if (got.tx_valid != want.tx_valid)
					report("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
				if (got.tx_byte != want.tx_byte)
					report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
				if (got.card_selected != want.card_selected)
					report("card_selected", 32'(got.card_selected), 32'(want.card_selected));
				if (got.finished != want.finished)
					report("finished", 32'(got.finished), 32'(want.finished));
				if (got.outcome != want.outcome)
					report("outcome", 32'(got.outcome), 32'(want.outcome));
				if (got.version_two != want.version_two)
					report("version_two", 32'(got.version_two), 32'(want.version_two));
				if (got.high_capacity != want.high_capacity)
					report("high_capacity", 32'(got.high_capacity), 32'(want.high_capacity));
				if (got.capacity_blocks != want.capacity_blocks)
					report("capacity_blocks", got.capacity_blocks, want.capacity_blocks);
				if (got.fast_clock != want.fast_clock)
					report("fast_clock", 32'(got.fast_clock), 32'(want.fast_clock));
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 0;
			end
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_READY_TIMEOUT:  p_ready_to = val;
			REG_OPCOND_TIMEOUT: p_opcond_to = val;
			default:            p_crc = val[7:0];
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Plays a card answering a command: ready, six frame bytes, R1 on a random try.
	task automatic cmd_exchange(input logic [7:0] r1, input int ticks);
		repeat (ticks) send_event(KIND_TICK, 8'($urandom));
		send_event(KIND_BYTE, 8'($urandom));
		send_event(KIND_BYTE, 8'($urandom));
		if ($urandom_range(0, 3) == 0) send_event(KIND_BYTE, 8'($urandom_range(0, 254)));
		send_event(KIND_BYTE, BYTE_IDLE);
		repeat (6) send_event(KIND_BYTE, 8'($urandom));
		repeat ($urandom_range(0, 3)) send_event(KIND_BYTE, 8'hFF);
		send_event(KIND_BYTE, r1);
	endtask

	// One well-formed start-up with random content and some broken choices.
	task automatic card_session();
		logic [1:0] flavour;
		int loops;
		flavour = 2'($urandom_range(0, 3));
		send_event(KIND_START, 8'($urandom));
		repeat (N_DUMMY) send_event(KIND_BYTE, 8'($urandom));
		send_event(KIND_BYTE, 8'($urandom));
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(0, 3)) send_event(KIND_TICK, 8'h00);
			send_event(KIND_BYTE, 8'($urandom_range(0, 254)));
		end
		send_event(KIND_BYTE, BYTE_IDLE);
		if (p_phase == PH_DONE) return;
		cmd_exchange($urandom_range(0, 15) == 0 ? 8'($urandom) : R1_IDLE, 0);
		if (p_phase == PH_DONE) return;
		cmd_exchange(flavour == 0 ? 8'h05 : R1_IDLE, 0);
		if (p_phase == PH_R7) begin
			send_event(KIND_BYTE, 8'($urandom));
			send_event(KIND_BYTE, 8'($urandom));
			send_event(KIND_BYTE, $urandom_range(0, 9) == 0 ? 8'($urandom) : VHS_27_36);
			send_event(KIND_BYTE, $urandom_range(0, 9) == 0 ? 8'($urandom) : CHECK_PAT);
		end
		loops = 0;
		while (p_phase != PH_DONE && (p_cmd == CMD_APP || p_cmd == CMD_OP_COND) && loops < 8) begin
			cmd_exchange(8'($urandom), $urandom_range(0, 3));
			if (p_phase == PH_DONE) break;
			cmd_exchange((loops > 2 || $urandom_range(0, 1)) ? 8'h00 : 8'h01, $urandom_range(0, 4));
			loops++;
		end
		if (p_phase == PH_DONE || !(p_cmd inside {CMD_READ_OCR, CMD_BLOCKLEN, CMD_SEND_CSD}))
			return;
		if (p_cmd == CMD_READ_OCR) begin
			cmd_exchange($urandom_range(0, 5) == 0 ? 8'h01 : 8'h00, 0);
			if (p_phase == PH_OCR) repeat (4) send_event(KIND_BYTE, 8'($urandom));
		end
		if (p_cmd == CMD_BLOCKLEN && p_phase != PH_DONE)
			cmd_exchange($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'h00, 0);
		if (p_phase == PH_DONE) return;
		cmd_exchange($urandom_range(0, 7) == 0 ? 8'h04 : 8'h00, 0);
		if (p_phase != PH_TOKEN) return;
		repeat ($urandom_range(0, 3)) begin
			send_event(KIND_TICK, 8'h00);
			send_event(KIND_BYTE, BYTE_IDLE);
		end
		send_event(KIND_BYTE, $urandom_range(0, 9) == 0 ? 8'($urandom) : BYTE_TOKEN);
		while (p_phase == PH_CSD) send_event(KIND_BYTE, 8'($urandom));
	endtask

	function automatic seq_result_t idle_result();
		return '0;
	endfunction

	stim_row_t rows[$];
	seq_result_t w;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_TICK;
		in_ch.rx_byte = 8'h00;
		p_ready_to = 16'd500; p_opcond_to = 16'd1000; p_crc = 8'd1;
		seq_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: idle behaviour, extremes of kind and byte
		w = idle_result();
		rows.push_back('{KIND_BYTE, 8'hFF, 1, w});
		rows.push_back('{KIND_TICK, 8'h00, 1, w});
		rows.push_back('{KIND_BAD, 8'h55, 1, w});
		w = '0; w.tx_valid = 1; w.tx_byte = BYTE_IDLE;
		rows.push_back('{KIND_START, 8'h00, 1, w});
		rows.push_back('{KIND_BAD, 8'hAA, 0, w});
		rows.push_back('{KIND_START, 8'hFF, 1, w});
		for (int i = 0; i < N_DUMMY + 1; i++) rows.push_back('{KIND_BYTE, 8'h00, 0, w});
		rows.push_back('{KIND_TICK, 8'h00, 0, w});
		rows.push_back('{KIND_BYTE, 8'h00, 0, w});
		w = '0; w.finished = 1; w.outcome = OUT_IF_ERR;
		write_reg(REG_READY_TIMEOUT, 16'd1);
		rows.push_back('{KIND_BYTE, 8'h12, 1, w});
		rows.push_back('{KIND_BYTE, 8'hFF, 1, w});
		foreach (rows[i]) send_event(rows[i].kind, rows[i].rx, rows[i].typed, rows[i].want);
		drain();

		write_reg(REG_READY_TIMEOUT, 16'd65535);
		write_reg(REG_OPCOND_TIMEOUT, 16'd1);
		write_reg(REG_FILLER_CRC, 16'hFFFF);
		for (int i = 0; i < 4; i++) card_session();
		drain();
		write_reg(REG_READY_TIMEOUT, 16'd2);
		write_reg(REG_OPCOND_TIMEOUT, 16'd65535);
		write_reg(REG_FILLER_CRC, 16'h0000);
		long_hold = 1;
		for (int i = 0; i < 4; i++) card_session();
		drain();
		write_reg(REG_READY_TIMEOUT, 16'd500);
		write_reg(REG_OPCOND_TIMEOUT, 16'd3);
		write_reg(REG_FILLER_CRC, 16'h0001);
		for (int i = 0; i < 4; i++) card_session();
		repeat (60) send_event(2'($urandom_range(0, 3)), 8'($urandom));
		drain();
		write_reg(REG_READY_TIMEOUT, 16'($urandom_range(1, 4)));
		write_reg(REG_OPCOND_TIMEOUT, 16'($urandom_range(1, 8)));
		write_reg(REG_FILLER_CRC, 16'($urandom_range(0, 255)));
		calm = 1;
		for (int i = 0; i < 3; i++) card_session();
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
